>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define VRBS_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define VRBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/vrbs_pkg.sv
package vrbs_pkg;

  localparam int unsigned STACK_BYTES_DEF  = 1024;
  localparam int unsigned HEADER_BYTES_DEF = 4;
  localparam int unsigned MAX_RECORD       = 64;

  localparam int unsigned LEN_W = 7;

  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_POP   = 3'd1;
  localparam logic [2:0] OP_PEEK  = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_EMPTY = 3'd4;
  localparam logic [2:0] OP_FIT   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SPACE = 2'd2;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

>>> design/vrbs_store.sv
module vrbs_store import vrbs_pkg::*; #(
  parameter int unsigned STACK_BYTES = STACK_BYTES_DEF,
  parameter int unsigned AW          = $clog2(STACK_BYTES)
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [STACK_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/variable_record_byte_stack_top.sv
// Variable-length record stack in a byte store that grows downward. Each request is taken
// when start is high and busy is low; every result appears on the out_ ports for exactly one
// cycle with out_valid high and cannot be held off, and the final result of a request carries
// out_last. All traffic goes through one byte-wide synchronous memory with a registered read,
// so timing follows the memory accesses: a push byte that does not complete its record, a
// rejected push byte, clear, the queries, a pop or peek of an empty stack and unused opcodes
// are answered straight from idle; the byte that completes a record (or a zero-length push)
// then writes the HEADER_BYTES bytes of the length header; a pop or peek of a non-empty stack
// stays busy to read the header, work out the byte count and then fetch the bytes returned,
// with the bytes streamed on consecutive cycles. A new request may be issued in the cycle in
// which the final result of the previous one is shown.
`include "assert_macros.svh"

module variable_record_byte_stack_top import vrbs_pkg::*; #(
  parameter int unsigned STACK_BYTES  = STACK_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       in_opcode,
  input  logic [LEN_W-1:0] in_length,
  input  logic [7:0]       in_data_byte,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_last,
  output logic             out_answer
);

  localparam int unsigned AW  = $clog2(STACK_BYTES);
  localparam int unsigned PW  = $clog2(STACK_BYTES + 1);
  localparam int unsigned XW  = PW + 1;
  localparam int unsigned NW  = 8 * HEADER_BYTES;
  localparam int unsigned HCW = $clog2(HEADER_BYTES + 1);
  localparam int unsigned SW  = ((NW > XW) ? NW : XW) + 1;
  localparam int unsigned LW  = LEN_W;

  localparam logic [PW-1:0] STACK_P = PW'(STACK_BYTES);
  localparam logic [PW-1:0] HDR_P   = PW'(HEADER_BYTES);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_HDR    = 5'b00010,
    S_RD_HDR = 5'b00100,
    S_CALC   = 5'b01000,
    S_RD_DAT = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [PW-1:0]    top_r, top_nxt;
  logic [LW-1:0]    pcount_r, pcount_nxt;
  logic [PW-1:0]    pbase_r, pbase_nxt;
  logic             prej_r, prej_nxt;
  logic [PW-1:0]    hdr_pos_r, hdr_pos_nxt;
  logic [LW-1:0]    hdr_len_r, hdr_len_nxt;
  logic [HCW-1:0]   hc_r, hc_nxt;
  logic [HCW-1:0]   rc_r, rc_nxt;
  logic             pend_r, pend_nxt;
  logic             pend_oob_r, pend_oob_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [LW-1:0]    rlen_r, rlen_nxt;
  logic             pop_r, pop_nxt;
  logic [LW-1:0]    cnt_r, cnt_nxt;
  logic [LW-1:0]    ic_r, ic_nxt;
  logic [XW-1:0]    rbase_r, rbase_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_bvalid_r, out_bvalid_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_answer_r, out_answer_nxt;

  mem_ctl_t         mem_ctl;
  logic [PW-1:0]    waddr_p;
  logic [7:0]       wdata;
  logic [XW-1:0]    raddr_x;
  logic [7:0]       rdata;
  logic             oob;
  logic [7:0]       rd_byte;

  logic             first;
  logic [XW-1:0]    need_x;
  logic             fit_bad;
  logic [PW-1:0]    eff_base;
  logic [LW-1:0]    pcount_inc;
  logic             push_end;

  logic [NW+7:0]    n_shift;
  logic [LW-1:0]    cnt_a;
  logic [LW-1:0]    cnt_c;
  logic [SW-1:0]    nt;
  logic [PW-1:0]    nt_sat;

  vrbs_store #(
    .STACK_BYTES (STACK_BYTES),
    .AW          (AW)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (waddr_p[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr_x[AW-1:0]),
    .rdata (rdata)
  );

  // Admission and addressing of push bytes; the admission check is shared with the fit query.
  assign first      = (pcount_r == '0);
  assign need_x     = XW'(in_length) + XW'(HEADER_BYTES);
  assign fit_bad    = (in_length > LW'(MAX_RECORD)) || (XW'(top_r) < need_x);
  assign eff_base   = first ? (top_r - PW'(in_length)) : pbase_r;
  assign pcount_inc = pcount_r + 1'b1;
  assign push_end   = (XW'(eff_base) + XW'(pcount_inc)) >= XW'(top_r);

  assign oob     = (raddr_x >= XW'(STACK_BYTES));
  assign rd_byte = pend_oob_r ? 8'h00 : rdata;

  // Header bytes arrive lowest first and are shifted in from the top.
  assign n_shift = {rd_byte, n_r};

  assign cnt_a  = (n_r < NW'(rlen_r)) ? LW'(n_r) : rlen_r;
  assign cnt_c  = (cnt_a > LW'(MAX_RECORD)) ? LW'(MAX_RECORD) : cnt_a;
  assign nt     = SW'(top_r) + SW'(HEADER_BYTES) + SW'(n_r);
  assign nt_sat = (nt > SW'(STACK_BYTES)) ? STACK_P : PW'(nt);

  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    pcount_nxt     = pcount_r;
    pbase_nxt      = pbase_r;
    prej_nxt       = prej_r;
    hdr_pos_nxt    = hdr_pos_r;
    hdr_len_nxt    = hdr_len_r;
    hc_nxt         = hc_r;
    rc_nxt         = rc_r;
    pend_nxt       = 1'b0;
    pend_oob_nxt   = 1'b0;
    n_nxt          = n_r;
    rlen_nxt       = rlen_r;
    pop_nxt        = pop_r;
    cnt_nxt        = cnt_r;
    ic_nxt         = ic_r;
    rbase_nxt      = rbase_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_byte_nxt   = 8'h00;
    out_bvalid_nxt = 1'b0;
    out_last_nxt   = 1'b0;
    out_answer_nxt = 1'b0;
    mem_ctl        = '0;
    waddr_p        = '0;
    wdata          = 8'h00;
    raddr_x        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_opcode inside {OP_POP, OP_PEEK, OP_CLEAR, OP_EMPTY, OP_FIT}) begin
            // Any of these abandons a push in progress.
            pcount_nxt = '0;
            pbase_nxt  = '0;
            prej_nxt   = 1'b0;
          end
          case (in_opcode)
            OP_PUSH: begin
              if (prej_r) begin
                if (PW'(pcount_inc) >= pbase_r) begin
                  pcount_nxt = '0;
                  pbase_nxt  = '0;
                  prej_nxt   = 1'b0;
                end else begin
                  pcount_nxt = pcount_inc;
                end
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = ST_SPACE;
              end else if (first && fit_bad) begin
                // A record of one byte or less is rejected by this request alone.
                if (in_length > LW'(1)) begin
                  prej_nxt   = 1'b1;
                  pbase_nxt  = PW'(in_length);
                  pcount_nxt = LW'(1);
                end
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = ST_SPACE;
              end else if (first && (in_length == '0)) begin
                hdr_pos_nxt = top_r - HDR_P;
                hdr_len_nxt = '0;
                hc_nxt      = '0;
                state_nxt   = S_HDR;
              end else begin
                mem_ctl.we = 1'b1;
                waddr_p    = eff_base + PW'(pcount_r);
                wdata      = in_data_byte;
                if (push_end) begin
                  hdr_pos_nxt = eff_base - HDR_P;
                  hdr_len_nxt = LW'(top_r - eff_base);
                  hc_nxt      = '0;
                  pcount_nxt  = '0;
                  pbase_nxt   = '0;
                  state_nxt   = S_HDR;
                end else begin
                  pcount_nxt    = pcount_inc;
                  pbase_nxt     = eff_base;
                  out_valid_nxt = 1'b1;
                  out_last_nxt  = 1'b1;
                end
              end
            end
            OP_POP, OP_PEEK: begin
              if (top_r >= STACK_P) begin
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                rc_nxt    = '0;
                n_nxt     = '0;
                rlen_nxt  = in_length;
                pop_nxt   = (in_opcode == OP_POP);
                state_nxt = S_RD_HDR;
              end
            end
            OP_CLEAR: begin
              top_nxt       = STACK_P;
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
            end
            OP_EMPTY: begin
              out_valid_nxt  = 1'b1;
              out_last_nxt   = 1'b1;
              out_answer_nxt = (top_r >= STACK_P);
            end
            OP_FIT: begin
              out_valid_nxt  = 1'b1;
              out_last_nxt   = 1'b1;
              out_answer_nxt = fit_bad;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
            end
          endcase
        end
      end

      S_HDR: begin
        mem_ctl.we = 1'b1;
        waddr_p    = hdr_pos_r + PW'(hc_r);
        wdata      = (hc_r == '0) ? {1'b0, hdr_len_r} : 8'h00;
        if (hc_r == HCW'(HEADER_BYTES - 1)) begin
          top_nxt       = hdr_pos_r;
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          hc_nxt = hc_r + 1'b1;
        end
      end

      S_RD_HDR: begin
        raddr_x = XW'(top_r) + XW'(rc_r);
        if (rc_r != HCW'(HEADER_BYTES)) begin
          mem_ctl.re   = !oob;
          pend_nxt     = 1'b1;
          pend_oob_nxt = oob;
          rc_nxt       = rc_r + 1'b1;
        end else begin
          state_nxt = S_CALC;
        end
        if (pend_r) begin
          n_nxt = n_shift[NW+7:8];
        end
      end

      S_CALC: begin
        rbase_nxt = XW'(top_r) + XW'(HEADER_BYTES);
        if (pop_r) begin
          top_nxt = nt_sat;
        end
        if (cnt_c == '0) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cnt_nxt   = cnt_c;
          ic_nxt    = '0;
          state_nxt = S_RD_DAT;
        end
      end

      S_RD_DAT: begin
        raddr_x = rbase_r + XW'(ic_r);
        if (ic_r != cnt_r) begin
          mem_ctl.re   = !oob;
          pend_nxt     = 1'b1;
          pend_oob_nxt = oob;
          ic_nxt       = ic_r + 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
        // The byte fetched in the previous cycle goes straight out.
        if (pend_r) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = rd_byte;
          out_bvalid_nxt = 1'b1;
          out_last_nxt   = (ic_r == cnt_r);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= STACK_P;
      pcount_r    <= '0;
      pbase_r     <= '0;
      prej_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      pcount_r    <= pcount_nxt;
      pbase_r     <= pbase_nxt;
      prej_r      <= prej_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_pos_r    <= hdr_pos_nxt;
    hdr_len_r    <= hdr_len_nxt;
    hc_r         <= hc_nxt;
    rc_r         <= rc_nxt;
    pend_oob_r   <= pend_oob_nxt;
    n_r          <= n_nxt;
    rlen_r       <= rlen_nxt;
    pop_r        <= pop_nxt;
    cnt_r        <= cnt_nxt;
    ic_r         <= ic_nxt;
    rbase_r      <= rbase_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_bvalid_r <= out_bvalid_nxt;
    out_last_r   <= out_last_nxt;
    out_answer_r <= out_answer_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bvalid_r;
  assign out_last       = out_last_r;
  assign out_answer     = out_answer_r;

  `VRBS_ASSERT_HOLDS(a_last_frees_block, clk, rst_n, out_valid && out_last, state_r == S_IDLE, "final result shown while the sequencer is still busy")
  `VRBS_ASSERT_HOLDS(a_mid_is_stream, clk, rst_n, out_valid && !out_last, (state_r == S_RD_DAT) && out_byte_valid, "non-final result outside a byte stream")
  `VRBS_ASSERT_HOLDS(a_reject_count, clk, rst_n, prej_r, (pcount_r != '0) && (PW'(pcount_r) < pbase_r), "rejected push count out of step with its length")
  `VRBS_ASSERT_NEXT(a_pop_progress, clk, rst_n, start && !busy && (in_opcode == OP_POP), busy || out_valid, "pop request neither started nor answered")

endmodule
